FILE: rtl/core/i2c_master_bit_sequencer_macros.svh
// ----------------------------------------------------------------------------
// I2C master bit sequencer assertion macros
// Concurrent check helpers clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_SEQUENCER_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_MACROS_SVH

// same-cycle implication
`define I2CMBS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define I2CMBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/i2cmbs_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Command codes, field widths and command slot lengths.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmbs_pkg;

	typedef enum logic [2:0] {
		CMD_START   = 3'd0,
		CMD_STOP    = 3'd1,
		CMD_TX_BYTE = 3'd2,
		CMD_RX_BYTE = 3'd3,
		CMD_TX_ACK  = 3'd4,
		CMD_RX_ACK  = 3'd5
	} cmd_t;

	localparam int SLOT_W = 5;
	localparam int BYTE_W = 8;
	localparam logic [BYTE_W-1:0] RX_MSB = 8'h80;

	typedef enum logic [1:0] {
		PH_DRIVE = 2'd0,
		PH_HIGH  = 2'd1,
		PH_LOW   = 2'd2
	} phase_t;

	function automatic logic [SLOT_W-1:0] cmd_len(input logic [2:0] kind);
		logic [SLOT_W-1:0] len;
		case (kind)
			CMD_START:   len = 5'd4;
			CMD_STOP:    len = 5'd3;
			CMD_TX_BYTE: len = 5'd24;
			CMD_RX_BYTE: len = 5'd25;
			CMD_TX_ACK:  len = 5'd3;
			default:     len = 5'd4;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/i2c_master_bit_sequencer.sv
// Output: registered; an accepted slot request's result is on m_tdata in the cycle after it is taken.
// Throughput: one slot request per cycle; the sequencer state register and the
// result register update together, and s_tready drops only while a result waits.
// Reset: asynchronous, idle, SCL and SDA released high, ack level one.
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Open-drain line sequencer stepping start/stop/byte/ack commands slot by slot.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_sequencer
	import i2cmbs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // tx_byte[7:0], ack_bit[8], sda_in[9], zero fill
	input  wire logic [3:0]  s_tuser,  // cmd_valid[0], func[3:1]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata   // scl_out[0], sda_out[1], busy_res[2], done_res[3],
	                                   // rx_byte[11:4], rx_ack[12], cmd_rejected[13], zero fill
);

	logic              cmd_valid, ack_bit, sda_in;
	logic [2:0]        func;
	logic [BYTE_W-1:0] tx_byte;

	logic              busy_q, scl_q, sda_q, ack_q, m_tvalid_q;
	logic [2:0]        kind_q;
	logic [SLOT_W-1:0] slot_q;
	logic [1:0]        ph_q;
	logic [2:0]        bit_q;
	logic [BYTE_W-1:0] shift_q, rx_q;
	logic [13:0]       out_q;

	logic              accept, start_cmd, active, rejected, done;
	logic [2:0]        kind;
	logic [SLOT_W-1:0] idx;
	logic [1:0]        ph;
	logic [2:0]        bt;
	logic [BYTE_W-1:0] shift;

	logic              busy_n, scl_n, sda_n, ack_n;
	logic [SLOT_W-1:0] slot_n;
	logic [1:0]        ph_n;
	logic [2:0]        bit_n;
	logic [BYTE_W-1:0] shift_n, rx_n;

	assign cmd_valid = s_tuser[0];
	assign func      = s_tuser[3:1];
	assign tx_byte   = s_tdata[7:0];
	assign ack_bit   = s_tdata[8];
	assign sda_in    = s_tdata[9];

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, out_q};

	assign start_cmd = !busy_q && cmd_valid && (func <= 3'(CMD_RX_ACK));
	assign rejected  = busy_q && cmd_valid;
	assign active    = busy_q || start_cmd;
	assign kind      = start_cmd ? func : kind_q;
	assign idx       = start_cmd ? '0 : slot_q;
	assign ph        = start_cmd ? 2'(PH_DRIVE) : ph_q;
	assign bt        = start_cmd ? '0 : bit_q;
	assign shift     = (start_cmd && func == 3'(CMD_TX_BYTE)) ? tx_byte :
	                   (start_cmd && func == 3'(CMD_TX_ACK))  ? {7'd0, ack_bit} : shift_q;

	always_comb begin
		scl_n   = scl_q;
		sda_n   = sda_q;
		ack_n   = ack_q;
		rx_n    = rx_q;
		shift_n = shift;
		ph_n    = ph;
		bit_n   = bt;
		busy_n  = busy_q;
		slot_n  = slot_q;
		done    = 1'b0;
		if (active) begin
			case (kind)
				CMD_START: begin
					case (idx)
						5'd0:    sda_n = 1'b1;
						5'd1:    scl_n = 1'b1;
						5'd2:    sda_n = 1'b0;
						default: scl_n = 1'b0;
					endcase
				end
				CMD_STOP: begin
					case (idx)
						5'd0:    sda_n = 1'b0;
						5'd1:    scl_n = 1'b1;
						default: sda_n = 1'b1;
					endcase
				end
				CMD_TX_BYTE: begin
					case (ph)
						PH_DRIVE: sda_n = shift[BYTE_W-1];
						PH_HIGH:  scl_n = 1'b1;
						default: begin
							scl_n   = 1'b0;
							shift_n = {shift[BYTE_W-2:0], 1'b0};
						end
					endcase
					ph_n = (ph == 2'(PH_LOW)) ? 2'(PH_DRIVE) : ph + 2'd1;
				end
				CMD_RX_BYTE: begin
					if (idx == '0) begin
						sda_n = 1'b1;
						rx_n  = '0;
					end else begin
						case (ph)
							PH_DRIVE: scl_n = 1'b1;
							PH_HIGH: begin
								if (sda_in)
									rx_n = rx_q | (RX_MSB >> bt);
							end
							default: begin
								scl_n = 1'b0;
								bit_n = bt + 3'd1;
							end
						endcase
						ph_n = (ph == 2'(PH_LOW)) ? 2'(PH_DRIVE) : ph + 2'd1;
					end
				end
				CMD_TX_ACK: begin
					case (idx)
						5'd0:    sda_n = |shift;
						5'd1:    scl_n = 1'b1;
						default: scl_n = 1'b0;
					endcase
				end
				default: begin
					case (idx)
						5'd0:    sda_n = 1'b1;
						5'd1:    scl_n = 1'b1;
						5'd2:    ack_n = sda_in;
						default: scl_n = 1'b0;
					endcase
				end
			endcase
			if ((6'(idx) + 6'd1) >= 6'(cmd_len(kind))) begin
				done   = 1'b1;
				busy_n = 1'b0;
				slot_n = '0;
			end else begin
				busy_n = 1'b1;
				slot_n = idx + 5'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			kind_q     <= '0;
			slot_q     <= '0;
			ph_q       <= '0;
			bit_q      <= '0;
			shift_q    <= '0;
			rx_q       <= '0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
			ack_q      <= 1'b1;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q  <= busy_n;
				kind_q  <= kind;
				slot_q  <= slot_n;
				ph_q    <= ph_n;
				bit_q   <= bit_n;
				shift_q <= shift_n;
				rx_q    <= rx_n;
				scl_q   <= scl_n;
				sda_q   <= sda_n;
				ack_q   <= ack_n;
			end
			if (accept)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			out_q <= {rejected, ack_n, rx_n, done, busy_n, sda_n, scl_n};
	end

`include "i2c_master_bit_sequencer_macros.svh"

	`I2CMBS_ASSERT_NOW(a_done_not_busy, m_tvalid, !(m_tdata[3] && m_tdata[2]), "done with busy")
	`I2CMBS_ASSERT_NOW(a_slot_in_range, busy_q, slot_q < cmd_len(kind_q), "slot out of range")
	`I2CMBS_ASSERT_NOW(a_idle_slot_zero, !busy_q, slot_q == '0, "idle with slot count")
	`I2CMBS_ASSERT_NEXT(a_reject_flag, accept && busy_q && cmd_valid, m_tvalid && m_tdata[13], "reject lost")

endmodule

`default_nettype wire
